/* sv/bod_pkg.sv */
// Shared types and constants for the bounded ordered deque.
`timescale 1ns / 1ps
`default_nettype none

package bod_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_REMOVE     = 3'd5;
    localparam logic [2:0] OP_LOOKUP     = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic head_inc;
        logic head_dec;
    } ring_ctl_t;

endpackage

`default_nettype wire

/* sv/bod_ring.sv */
// Circular entry store addressed relative to the front of the sequence.
`timescale 1ns / 1ps
`default_nettype none

module bod_ring
    import bod_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ring_ctl_t                    ctl,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_idx,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_idx,
    input  wire logic [DATA_W-1:0]            wr_data,
    output logic      [DATA_W-1:0]            rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     rd_phys;
    logic [AW-1:0]     wr_phys;
    logic [DATA_W-1:0] rd_data_reg;

    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_phys = to_phys(head_reg, rd_idx);
    assign wr_phys = to_phys(head_reg, wr_idx);
    assign rd_data = rd_data_reg;

    always_comb
    begin
        head_next = head_reg;
        if (ctl.head_dec)
        begin
            head_next = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
        end
        else if (ctl.head_inc)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_phys] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_phys];
        end
    end

endmodule

`default_nettype wire

/* sv/bounded_ordered_deque.sv */
// Top level of the bounded ordered deque: sequencer, scan and shift over the store.
// Push back, full store, empty store and unused op go from idle straight to the finish state;
// push front and pops pass a put or pop state; insert scans, shifts and puts; remove scans and shifts; lookup scans.
// One word at a time: the next is taken once the result is registered, later if the output stalls.
// Reset: control and count cleared at once; stored entries stay undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_deque
    import bod_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    op,
    input  wire logic signed [DATA_W-1:0]      value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [DATA_W-1:0]           result_value,
    output logic                               found,
    output logic [1:0]                         status,
    output logic                               is_empty,
    output logic [$clog2(DEPTH+1)-1:0]         entry_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_POP    = 6'b001000,
        S_PUT    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [2:0]                op_reg, op_next;
    logic signed [DATA_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic [DATA_W-1:0]         res_reg, res_next;
    logic                      found_reg, found_next;
    logic [1:0]                status_reg, status_next;

    logic                      out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]         out_value_reg, out_value_next;
    logic                      out_found_reg, out_found_next;
    logic [1:0]                out_status_reg, out_status_next;
    logic                      out_empty_reg, out_empty_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;

    ring_ctl_t                 ctl;
    logic [CNT_W-1:0]          rd_idx, wr_idx;
    logic [DATA_W-1:0]         wr_data, rd_data;

    logic                      accept;
    logic                      hit;
    logic [CNT_W-1:0]          idx_inc;
    logic [CNT_W-1:0]          count_dec;
    logic                      out_free;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign hit       = (op_reg == OP_INSERT) ? !($signed(rd_data) < value_reg)
                                             : (rd_data == value_reg);

    bod_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_idx  (rd_idx[AW-1:0]),
        .wr_idx  (wr_idx[AW-1:0]),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        res_next    = res_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ctl         = '0;
        rd_idx      = '0;
        wr_idx      = '0;
        wr_data     = rd_data;

        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_empty_next  = out_empty_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op;
                    value_next  = value;
                    res_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_FINISH;
                    if (op inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT})
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (op == OP_PUSH_BACK)
                        begin
                            ctl.wr_en  = 1'b1;
                            wr_idx     = count_reg;
                            wr_data    = value;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else if (op == OP_PUSH_FRONT || count_reg == '0)
                        begin
                            ctl.head_dec = 1'b1;
                            pos_next     = '0;
                            state_next   = S_PUT;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            rd_idx     = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (op inside {OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_LOOKUP})
                    begin
                        if (count_reg == '0)
                        begin
                            if (op != OP_LOOKUP)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        else if (op == OP_POP_FRONT || op == OP_POP_BACK)
                        begin
                            ctl.rd_en  = 1'b1;
                            rd_idx     = (op == OP_POP_BACK) ? count_dec : '0;
                            state_next = S_POP;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            rd_idx     = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pos_next = idx_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        if (idx_reg == '0)
                        begin
                            ctl.head_dec = 1'b1;
                            state_next   = S_PUT;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            rd_idx     = count_dec;
                            idx_next   = count_dec;
                            state_next = S_SHIFT;
                        end
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        found_next = 1'b1;
                        if (idx_reg == '0)
                        begin
                            ctl.head_inc = 1'b1;
                            count_next   = count_dec;
                            state_next   = S_FINISH;
                        end
                        else if (idx_reg == count_dec)
                        begin
                            count_next = count_dec;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            rd_idx     = idx_inc;
                            idx_next   = idx_inc;
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        found_next = 1'b1;
                        state_next = S_FINISH;
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = (op_reg == OP_INSERT) ? S_PUT : S_FINISH;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    rd_idx    = idx_inc;
                    idx_next  = idx_inc;
                end
            end

            S_SHIFT:
            begin
                ctl.wr_en = 1'b1;
                wr_data   = rd_data;
                if (op_reg == OP_INSERT)
                begin
                    wr_idx = idx_inc;
                    if (idx_reg == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ctl.rd_en = 1'b1;
                        rd_idx    = idx_reg - CNT_W'(1);
                        idx_next  = idx_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    wr_idx = idx_reg - CNT_W'(1);
                    if (idx_reg == count_dec)
                    begin
                        count_next = count_dec;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ctl.rd_en = 1'b1;
                        rd_idx    = idx_inc;
                        idx_next  = idx_inc;
                    end
                end
            end

            S_POP:
            begin
                res_next     = rd_data;
                ctl.head_inc = (op_reg == OP_POP_FRONT);
                count_next   = count_dec;
                state_next   = S_FINISH;
            end

            S_PUT:
            begin
                ctl.wr_en  = 1'b1;
                wr_idx     = pos_reg;
                wr_data    = value_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_reg;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_empty_next  = (count_reg == '0);
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        res_reg        <= res_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_empty_reg  <= out_empty_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = $signed(out_value_reg);
    assign found        = out_found_reg;
    assign status       = out_status_reg;
    assign is_empty     = out_empty_reg;
    assign entry_count  = out_count_reg;

endmodule

`default_nettype wire

/* tb/sv/bod_tb_pkg.sv */
// Scoreboard and shared testbench types for the bounded ordered deque.
`timescale 1ns / 1ps

package bod_tb_pkg;

    import bod_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int         CAPACITY  = DEPTH_DEF;
    localparam int         COUNT_W   = $clog2(DEPTH_DEF + 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     found;
        logic [1:0]               status;
        logic                     is_empty;
        logic [COUNT_W-1:0]       entry_count;
    } deque_reply_t;

    class deque_scoreboard;

        logic signed [DATA_W-1:0] held[$];
        deque_reply_t             awaited[$];
        int                       words_in    = 0;
        int                       replies_in  = 0;
        int                       failures    = 0;
        int                       reported    = 0;
        int                       full_drops  = 0;
        int                       empty_hits  = 0;
        int                       match_hits  = 0;
        int                       op_tally[8] = '{default: 0};

        function automatic int locate(logic signed [DATA_W-1:0] v);
            foreach (held[i])
            begin
                if (held[i] == v)
                    return i;
            end
            return -1;
        endfunction

        function automatic deque_reply_t apply_word(logic [2:0] op,
                                                    logic signed [DATA_W-1:0] v);
            deque_reply_t r;
            int           pos;
            r        = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
                begin
                    if (held.size() >= CAPACITY)
                        r.status = ST_FULL;
                    else if (op == OP_PUSH_FRONT)
                        held.push_front(v);
                    else if (op == OP_PUSH_BACK)
                        held.push_back(v);
                    else
                    begin
                        pos = 0;
                        while (pos < held.size() && held[pos] < v)
                            pos++;
                        held.insert(pos, v);
                    end
                end
                OP_POP_FRONT:
                begin
                    if (held.size() == 0)
                        r.status = ST_EMPTY;
                    else
                        r.result_value = held.pop_front();
                end
                OP_POP_BACK:
                begin
                    if (held.size() == 0)
                        r.status = ST_EMPTY;
                    else
                        r.result_value = held.pop_back();
                end
                OP_REMOVE:
                begin
                    if (held.size() == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        pos = locate(v);
                        if (pos >= 0)
                        begin
                            held.delete(pos);
                            r.found = 1'b1;
                        end
                    end
                end
                OP_LOOKUP:
                    r.found = (locate(v) >= 0);
                default:
                    ;
            endcase
            r.is_empty    = (held.size() == 0);
            r.entry_count = COUNT_W'(held.size());
            return r;
        endfunction

        function automatic void note_word(logic [2:0] op, logic signed [DATA_W-1:0] v);
            deque_reply_t r;
            r = apply_word(op, v);
            awaited.push_back(r);
            words_in++;
            op_tally[op]++;
            if (r.status == ST_FULL)
                full_drops++;
            if (r.status == ST_EMPTY)
                empty_hits++;
            if (r.found)
                match_hits++;
        endfunction

        function automatic void flag_field(string name, logic [DATA_W-1:0] want,
                                           logic [DATA_W-1:0] got);
            reported++;
            if (reported <= 10)
                $display("result %0d: %s expected %h, got %h", replies_in, name, want, got);
        endfunction

        function automatic void check_reply(deque_reply_t got);
            deque_reply_t want;
            bit           bad;
            replies_in++;
            if (awaited.size() == 0)
            begin
                failures++;
                reported++;
                if (reported <= 10)
                    $display("result %0d: no word outstanding, got %h", replies_in, got);
                return;
            end
            want = awaited.pop_front();
            bad  = 1'b0;
            if (got.result_value !== want.result_value)
            begin
                flag_field("result_value", want.result_value, got.result_value);
                bad = 1'b1;
            end
            if (got.found !== want.found)
            begin
                flag_field("found", DATA_W'(want.found), DATA_W'(got.found));
                bad = 1'b1;
            end
            if (got.status !== want.status)
            begin
                flag_field("status", DATA_W'(want.status), DATA_W'(got.status));
                bad = 1'b1;
            end
            if (got.is_empty !== want.is_empty)
            begin
                flag_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
                bad = 1'b1;
            end
            if (got.entry_count !== want.entry_count)
            begin
                flag_field("entry_count", DATA_W'(want.entry_count),
                           DATA_W'(got.entry_count));
                bad = 1'b1;
            end
            if (bad)
                failures++;
        endfunction

        function automatic logic signed [DATA_W-1:0] any_held();
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

    endclass

endpackage

/* tb/sv/tb_top.sv */
// Top-level testbench for the bounded ordered deque: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_top;

    import bod_pkg::*;
    import bod_tb_pkg::*;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SORTED} burst_mode_e;

    localparam int                       RANDOM_WORDS = 1200;
    localparam int                       LONG_HOLD    = 400;
    localparam int                       HOLD_AT      = 40;
    localparam logic signed [DATA_W-1:0] V_MIN        = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] V_MAX        = 32'sh7FFF_FFFF;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [2:0]               op_in     = '0;
    logic signed [DATA_W-1:0] value_in  = '0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [DATA_W-1:0] result_value;
    logic                     found;
    logic [1:0]               status;
    logic                     is_empty;
    logic [COUNT_W-1:0]       entry_count;

    deque_scoreboard sb = new;
    int              send_gap_max = 18;
    int              results_seen = 0;

    bounded_ordered_deque #(.DEPTH(DEPTH_DEF)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op_in),
        .value        (value_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .found        (found),
        .status       (status),
        .is_empty     (is_empty),
        .entry_count  (entry_count)
    );

    always #6 clk = ~clk;

    initial
    begin
        #8000000;
        $display("[bounded_ordered_deque] ERROR");
        $finish;
    end

    task automatic send_word(input logic [2:0] o, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op_in    <= o;
        value_in <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(o, v);
    endtask

    function automatic logic [2:0] pick_op(burst_mode_e m);
        int r;
        r = $urandom_range(0, 99);
        case (m)
            MODE_FILL:
            begin
                if (r < 80)
                    return 3'($urandom_range(OP_PUSH_FRONT, OP_INSERT));
                if (r < 90)
                    return (r < 85) ? OP_REMOVE : OP_LOOKUP;
                return 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
            end
            MODE_DRAIN:
            begin
                if (r < 70)
                    return 3'($urandom_range(OP_POP_FRONT, OP_REMOVE));
                if (r < 80)
                    return OP_LOOKUP;
                if (r < 95)
                    return 3'($urandom_range(OP_PUSH_FRONT, OP_INSERT));
                return OP_UNUSED;
            end
            MODE_SORTED:
            begin
                if (r < 50)
                    return OP_INSERT;
                if (r < 75)
                    return OP_REMOVE;
                if (r < 90)
                    return OP_LOOKUP;
                return 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
            end
            default:
            begin
                if (r < 3)
                    return OP_UNUSED;
                return 3'($urandom_range(OP_PUSH_FRONT, OP_LOOKUP));
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(logic [2:0] o);
        int r;
        r = $urandom_range(0, 9);
        if ((o == OP_REMOVE || o == OP_LOOKUP) && sb.held.size() > 0 && r < 6)
            return sb.any_held();
        if (r < 4)
            return DATA_W'(int'($urandom_range(0, 16)) - 8);
        if (r == 4)
        begin
            case ($urandom_range(0, 3))
                0:       return V_MIN;
                1:       return V_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic run_burst(input burst_mode_e m, input int len, input int gap_max);
        logic [2:0] o;
        send_gap_max = gap_max;
        repeat (len)
        begin
            o = pick_op(m);
            send_word(o, pick_value(o));
        end
    endtask

    initial
    begin
        int          hold;
        int          hold_max;
        deque_reply_t got;
        hold_max = 18;
        @(posedge rst_n);
        forever
        begin
            if (results_seen % 50 == 0)
                hold_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            hold = (results_seen == HOLD_AT) ? LONG_HOLD : $urandom_range(0, hold_max);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.result_value = result_value;
            got.found        = found;
            got.status       = status;
            got.is_empty     = is_empty;
            got.entry_count  = entry_count;
            sb.check_reply(got);
            results_seen++;
        end
    end

    initial
    begin
        int          stop_at;
        burst_mode_e m;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_POP_FRONT, V_MAX);
        send_word(OP_POP_BACK, V_MIN);
        send_word(OP_REMOVE, 5);
        send_word(OP_LOOKUP, 0);
        send_word(OP_UNUSED, '1);
        send_word(OP_PUSH_BACK, V_MAX);
        send_word(OP_PUSH_FRONT, V_MIN);
        send_word(OP_INSERT, 0);
        send_word(OP_INSERT, 0);
        send_word(OP_INSERT, -1);
        send_word(OP_INSERT, V_MAX);
        send_word(OP_INSERT, V_MIN);
        send_word(OP_LOOKUP, V_MAX);
        send_word(OP_LOOKUP, 12345);
        send_word(OP_REMOVE, 999);
        send_word(OP_REMOVE, 0);
        send_word(OP_UNUSED, 0);
        send_word(OP_POP_FRONT, 0);
        send_word(OP_POP_BACK, 0);
        send_word(OP_PUSH_FRONT, 32'sh5555_5555);
        send_word(OP_PUSH_BACK, 32'shAAAA_AAAA);

        // back-to-back words while the receiver holds off
        run_burst(MODE_FILL, 60, 0);
        stop_at = sb.words_in - 60 + RANDOM_WORDS;
        while (sb.words_in < stop_at)
        begin
            m = burst_mode_e'($urandom_range(MODE_FILL, MODE_SORTED));
            run_burst(m, $urandom_range(20, 80), ($urandom_range(0, 2) == 0) ? 0 : 18);
        end
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Checked %0d results from %0d words: ops 0-7 seen %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d.",
                 sb.replies_in, sb.words_in, sb.op_tally[0], sb.op_tally[1], sb.op_tally[2],
                 sb.op_tally[3], sb.op_tally[4], sb.op_tally[5], sb.op_tally[6],
                 sb.op_tally[7]);
        $display("Full-store drops %0d, empty-store errors %0d, matches %0d, mismatches %0d.",
                 sb.full_drops, sb.empty_hits, sb.match_hits, sb.failures);
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("[bounded_ordered_deque] OK");
        else
            $display("[bounded_ordered_deque] ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/bod_pkg.sv
sv/bod_ring.sv
sv/bounded_ordered_deque.sv
tb/sv/bod_tb_pkg.sv
tb/sv/tb_top.sv
